// ----- src/tml_pkg.sv -----
// Shared types and constants for the tar member lookup block.
package tml_pkg;
  localparam int NameLen = 100;
  localparam int AddrBits = 32;
  localparam int IdxBits = 7;
  localparam int SizeBits = 36;
  localparam int SkipBits = 37;
  localparam int HdrPosBits = 9;
  localparam logic [HdrPosBits-1:0] HdrLast = 9'd511;
  localparam logic [HdrPosBits-1:0] SizeFirst = 9'd124;
  localparam logic [HdrPosBits-1:0] SizeEnd = 9'd136;
  localparam logic [HdrPosBits-1:0] TypePos = 9'd156;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChSeven = 8'h37;
  localparam logic [7:0] ChDot = 8'h2e;
  localparam logic [7:0] ChSlash = 8'h2f;

  typedef enum logic [1:0] {
    OP_NAME = 2'd0,
    OP_BYTE = 2'd1,
    OP_START = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // classified item handed from front to back
  typedef struct packed {
    op_t op;
    logic [IdxBits-1:0] idx;
    logic [7:0] value;
    logic last;
  } item_t;

  typedef struct packed {
    logic found;
    logic [AddrBits-1:0] offset;
    logic [SizeBits-1:0] size;
  } result_t;
endpackage

// ----- src/tml_front.sv -----
// Front end: two-entry queue between the input port and the back end.
module tml_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tml_pkg::item_t  in_item,
  output logic            q_valid,
  input  logic            q_ready,
  output tml_pkg::item_t  q_item
);
  tml_pkg::item_t mem_r [2];
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = mem_r[rd_r];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_comb begin
    rd_nxt = pop ? ~rd_r : rd_r;
    wr_nxt = push ? ~wr_r : wr_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wr_r] <= in_item;
  end
endmodule

// ----- src/tml_back.sv -----
// Back end: name store, header parser, data skip and result register.
module tml_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  tml_pkg::item_t   q_item,
  output logic             res_valid,
  input  logic             res_ready,
  output tml_pkg::result_t res
);
  logic [7:0] name_r [tml_pkg::NameLen];
  logic [tml_pkg::NameLen-1:0] nvalid_r;
  logic [tml_pkg::AddrBits-1:0] pos_r;
  logic [tml_pkg::HdrPosBits-1:0] hpos_r;
  logic in_data_r, octal_r, dot_r, reg_r, over_r;
  logic [tml_pkg::SkipBits-1:0] skip_r;
  logic [tml_pkg::SizeBits-1:0] acc_r;
  logic [1:0] dm_r, sm_r;
  logic rv_r;
  tml_pkg::result_t res_r;
  logic [7:0] td_r, ts_r;

  logic go, emit, hit, hdr, dm_go, sm_go, t_last, wr_name, rd_d_ok, rd_s_ok;
  logic [7:0] b;
  logic [1:0] dm_n, sm_n, msel;
  logic [tml_pkg::AddrBits-1:0] pos_inc;
  logic [tml_pkg::HdrPosBits-1:0] hs, hpos_n;
  logic [tml_pkg::SkipBits-1:0] skip_new;

  // one result in flight at most; stall while it waits
  assign q_ready = !rv_r || res_ready;
  assign go = q_valid && q_ready;
  assign res_valid = rv_r;
  assign res = res_r;
  assign b = q_item.value;
  assign hdr = go && q_item.op == tml_pkg::OP_BYTE && !over_r && !in_data_r;
  assign wr_name = go && q_item.op == tml_pkg::OP_NAME &&
                   q_item.idx < 7'(tml_pkg::NameLen);
  assign pos_inc = pos_r + 1'b1;
  assign hs = hpos_n - 9'd2;
  assign dm_go = hpos_r < 9'(tml_pkg::NameLen);
  assign sm_go = hpos_r >= 9'd2 && hpos_r < 9'(tml_pkg::NameLen + 2);
  assign rd_d_ok = hpos_n < 9'(tml_pkg::NameLen);
  assign rd_s_ok = hpos_n >= 9'd2 && hpos_n < 9'(tml_pkg::NameLen + 2);
  assign t_last = hpos_r == tml_pkg::HdrLast;

  function automatic logic [1:0] cmp(input logic [1:0] st, input logic [7:0] a,
                                     input logic [7:0] t);
    logic [1:0] r;
    r = st;
    if (!st[0]) begin
      if (a != t) r = 2'b11;
      else if (a == 8'd0) r = 2'b01;
    end
    return r;
  endfunction

  always_comb begin
    dm_n = dm_go ? cmp(dm_r, b, td_r) : dm_r;
    sm_n = sm_go ? cmp(sm_r, b, ts_r) : sm_r;
    msel = dot_r ? sm_n : dm_n;
    hit = reg_r && !msel[1];
    skip_new = ({1'b0, acc_r} + 37'd511) & ~37'd511;
    // header position for the next item, also the name store read address
    hpos_n = hpos_r;
    if (go && q_item.op == tml_pkg::OP_START) begin
      hpos_n = '0;
    end else if (hdr && !(hpos_r == '0 && b == 8'd0)) begin
      if (!t_last) hpos_n = hpos_r + 1'b1;
      else if (!hit) hpos_n = '0;
    end
    emit = (go && q_item.op == tml_pkg::OP_BYTE && !over_r && in_data_r && q_item.last) ||
           (hdr && ((hpos_r == '0 && b == 8'd0) || (t_last && hit) || q_item.last));
  end

  // registered name store reads for the next header byte, with write forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      td_r <= 8'd0;
      ts_r <= 8'd0;
    end else begin
      if (!rd_d_ok) td_r <= 8'd0;
      else if (wr_name && q_item.idx == hpos_n[6:0]) td_r <= b;
      else if (nvalid_r[hpos_n[6:0]]) td_r <= name_r[hpos_n[6:0]];
      else td_r <= 8'd0;
      if (!rd_s_ok) ts_r <= 8'd0;
      else if (wr_name && q_item.idx == hs[6:0]) ts_r <= b;
      else if (nvalid_r[hs[6:0]]) ts_r <= name_r[hs[6:0]];
      else ts_r <= 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nvalid_r <= '0;
      pos_r <= '0;
      hpos_r <= '0;
      in_data_r <= 1'b0;
      skip_r <= '0;
      acc_r <= '0;
      octal_r <= 1'b1;
      dot_r <= 1'b0;
      dm_r <= 2'b00;
      sm_r <= 2'b00;
      reg_r <= 1'b0;
      over_r <= 1'b1;
      rv_r <= 1'b0;
    end else begin
      hpos_r <= hpos_n;
      if (rv_r && res_ready) rv_r <= 1'b0;
      if (wr_name) begin
        name_r[q_item.idx] <= b;
        nvalid_r[q_item.idx] <= 1'b1;
      end
      if (go && q_item.op == tml_pkg::OP_START) begin
        pos_r <= '0;
        in_data_r <= 1'b0;
        skip_r <= '0;
        acc_r <= '0;
        octal_r <= 1'b1;
        dot_r <= 1'b0;
        dm_r <= 2'b00;
        sm_r <= 2'b00;
        reg_r <= 1'b0;
        over_r <= 1'b0;
      end
      if (go && q_item.op == tml_pkg::OP_BYTE && !over_r && in_data_r) begin
        pos_r <= pos_inc;
        skip_r <= skip_r - 1'b1;
        if (skip_r == 37'd1) in_data_r <= 1'b0;
        if (q_item.last) res_r <= '0;
      end
      if (hdr) begin
        if (hpos_r == '0 && b == 8'd0) begin
          res_r <= '0;
        end else begin
          pos_r <= pos_inc;
          dm_r <= dm_n;
          sm_r <= sm_n;
          if (hpos_r == '0) dot_r <= (b == tml_pkg::ChDot);
          else if (hpos_r == 9'd1) dot_r <= dot_r && (b == tml_pkg::ChSlash);
          if (hpos_r >= tml_pkg::SizeFirst && hpos_r < tml_pkg::SizeEnd && octal_r) begin
            if (b >= tml_pkg::ChZero && b <= tml_pkg::ChSeven)
              acc_r <= {acc_r[tml_pkg::SizeBits-4:0], b[2:0]};
            else octal_r <= 1'b0;
          end
          if (hpos_r == tml_pkg::TypePos) reg_r <= (b == tml_pkg::ChZero || b == 8'd0);
          if (t_last) begin
            if (hit) begin
              res_r <= '{found: 1'b1, offset: pos_inc, size: acc_r};
            end else begin
              acc_r <= '0;
              octal_r <= 1'b1;
              dot_r <= 1'b0;
              dm_r <= 2'b00;
              sm_r <= 2'b00;
              reg_r <= 1'b0;
              skip_r <= skip_new;
              in_data_r <= skip_new != '0;
              if (q_item.last) res_r <= '0;
            end
          end else begin
            if (q_item.last) res_r <= '0;
          end
        end
      end
      if (emit) begin
        rv_r <= 1'b1;
        over_r <= 1'b1;
      end
    end
  end
endmodule

// ----- src/tar_member_lookup_top.sv -----
// Tar member lookup: one item per cycle, back to back, while no result waits.
// An input transfer lands in a two-entry front queue, from which the back end
// takes it; the back end handles each byte with one registered name store read
// and small counter updates, so a result is offered the cycle after the back end
// takes the item that ends the search. The back end stalls while a result waits
// untaken; once the queue holds two items the input stalls as well.
module tar_member_lookup_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // name_index[6:0], value[14:7], pad
  input  logic [1:0]  in_tuser,   // op[1:0]
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // data_offset[31:0], file_size[67:32], pad
  output logic        out_tuser   // found
);
  tml_pkg::item_t in_item, q_item;
  tml_pkg::result_t res;
  logic q_valid, q_ready;

  assign in_item = '{op: tml_pkg::op_t'(in_tuser), idx: in_tdata[6:0],
                     value: in_tdata[14:7], last: in_tlast};

  tml_front u_front (.clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
                     .in_item, .q_valid, .q_ready, .q_item);
  tml_back u_back (.clk, .rst_n, .q_valid, .q_ready, .q_item,
                   .res_valid(out_tvalid), .res_ready(out_tready), .res);

  assign out_tdata = {4'd0, res.size, res.offset};
  assign out_tuser = res.found;
endmodule

// ----- src/tml_checker.sv -----
// Port-level checker for the tar member lookup block.
module tml_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-found result carries data");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:68] == 4'd0)
    else $error("padding not zero");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
  a_ready_reset: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");
endmodule

bind tar_member_lookup_top tml_checker u_chk (.*);
